>>> rtl/core/remote_input_conditioner_macros.svh
// ----------------------------------------------------------------------------
// Remote input conditioner assertion macros
// Shared concurrent assertion forms used by the conditioner modules.
// ----------------------------------------------------------------------------
`ifndef REMOTE_INPUT_CONDITIONER_MACROS_SVH
`define REMOTE_INPUT_CONDITIONER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RIC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("conditioner assertion failed");

// Next-cycle implication, disabled during reset
`define RIC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("conditioner assertion failed");

`endif

>>> rtl/core/ric_pkg.sv
// ----------------------------------------------------------------------------
// Remote input conditioner package
// Types, register indexes and arithmetic constants shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ric_pkg;

  localparam int RIC_NUM_KEYS      = 18;
  localparam int RIC_MODIFIER_KEY  = 5;
  localparam int RIC_QUEUE_DEPTH   = 2;
  localparam int RIC_Q14_ONE       = 16384;
  localparam int RIC_STICK_CENTER  = 1024;

  // 16384/660 reduces to 4096/165. Scale |c| by ceil(2^32/165) and take
  // bits from 2^(32-12) up; exact for every |c| up to 1024.
  localparam int unsigned RIC_STICK_RECIP = 32'd26030105;
  localparam int RIC_STICK_SHIFT = 20;

  // Reset values of the configuration registers
  localparam logic [7:0]  RIC_GAIN_RST    = 8'd128;
  localparam logic [14:0] RIC_DZ_RST      = 15'd819;
  localparam logic [15:0] RIC_TIMEOUT_RST = 16'd100;
  localparam logic [15:0] RIC_STALE_RST   = 16'd1000;

  // Request codes as they arrive on req_type
  typedef enum logic [1:0] {
    OP_FRAME = 2'd0,
    OP_TICK  = 2'd1,
    OP_SCAN  = 2'd2,
    OP_NONE  = 2'd3
  } ric_op_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MOUSE_GAIN   = 3'd0,
    REG_DEAD_ZONE    = 3'd1,
    REG_LINK_TIMEOUT = 3'd2,
    REG_STALE_LIMIT  = 3'd3,
    REG_CLICK_ENABLE = 3'd4
  } ric_reg_t;

  typedef struct packed {
    logic [7:0]              mouse_gain;
    logic [14:0]             dead_zone;
    logic [15:0]             link_timeout_ms;
    logic [15:0]             stale_limit_ms;
    logic [RIC_NUM_KEYS-1:0] click_enable;
  } ric_cfg_t;

  // Classified word handed from the front to the back
  typedef struct packed {
    ric_op_t                 op;
    logic [3:0]              stick_neg;
    logic [3:0][14:0]        stick_mag;
    logic [2:0][24:0]        mouse_prod;
    logic [RIC_NUM_KEYS-1:0] pressed;
    logic [31:0]             now_ms;
  } ric_item_t;

  typedef struct packed {
    logic [6:0][15:0]        norm;
    logic                    link_up;
    logic [RIC_NUM_KEYS-1:0] click_events;
    logic [RIC_NUM_KEYS-1:0] pressed_keys;
  } ric_result_t;

endpackage

`default_nettype wire

>>> rtl/core/ric_front.sv
// ----------------------------------------------------------------------------
// Remote input conditioner front end
// Accepts input words, decodes the request and forms the stick and mouse
// products that the back end finishes.
// ----------------------------------------------------------------------------
`default_nettype none

module ric_front import ric_pkg::*; (
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic [10:0]        stick_right_x,
  input  wire logic [10:0]        stick_right_y,
  input  wire logic [10:0]        stick_left_x,
  input  wire logic [10:0]        stick_left_y,
  input  wire logic signed [15:0] mouse_dx,
  input  wire logic signed [15:0] mouse_dy,
  input  wire logic signed [15:0] mouse_dz,
  input  wire logic [7:0]         left_button,
  input  wire logic [7:0]         right_button,
  input  wire logic [15:0]        key_bits,
  input  wire logic [31:0]        now_ms,
  input  wire logic [7:0]         mouse_gain,
  input  wire logic               q_full,
  output      logic               push,
  output      ric_item_t          item
);

  logic [10:0]        stick_raw [4];
  logic [10:0]        stick_abs [4];
  logic [35:0]        stick_prod [4];
  logic signed [15:0] mouse_raw [3];

  assign stick_raw[0] = stick_right_x;
  assign stick_raw[1] = stick_right_y;
  assign stick_raw[2] = stick_left_x;
  assign stick_raw[3] = stick_left_y;
  assign mouse_raw[0] = mouse_dx;
  assign mouse_raw[1] = mouse_dy;
  assign mouse_raw[2] = mouse_dz;

  // Take a word whenever the queue has room
  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // Build the classified word
  always_comb begin
    // Decode the request
    unique case (req_type)
      OP_FRAME: item.op = OP_FRAME;
      OP_TICK:  item.op = OP_TICK;
      OP_SCAN:  item.op = OP_SCAN;
      default:  item.op = OP_NONE;
    endcase

    // Stick magnitude about center, scaled by the reciprocal of 660/16384
    for (int k = 0; k < 4; k++) begin
      item.stick_neg[k] = !stick_raw[k][10];
      stick_abs[k] = item.stick_neg[k] ? (11'(RIC_STICK_CENTER) - stick_raw[k])
                                       : (stick_raw[k] - 11'(RIC_STICK_CENTER));
      stick_prod[k] = 36'(stick_abs[k]) * 36'(RIC_STICK_RECIP);
      item.stick_mag[k] = stick_prod[k][RIC_STICK_SHIFT +: 15];
    end

    // Mouse axes times the unsigned gain
    for (int k = 0; k < 3; k++) begin
      item.mouse_prod[k] = $signed({1'b0, mouse_gain}) * mouse_raw[k];
    end

    // Pressed flags: keyboard bitmap plus the two mouse buttons
    item.pressed = {right_button == 8'd1, left_button == 8'd1, key_bits};
    item.now_ms  = now_ms;
  end

endmodule

`default_nettype wire

>>> rtl/core/ric_queue.sv
// ----------------------------------------------------------------------------
// Remote input conditioner queue
// Short register FIFO of classified words between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ric_queue import ric_pkg::*; #(
  parameter int DEPTH = RIC_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire ric_item_t wr_item,
  output      logic      full,
  input  wire logic      pop,
  output      logic      q_valid,
  output      ric_item_t rd_item
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ric_item_t        entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign q_valid = (count != '0);
  assign rd_item = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  `include "remote_input_conditioner_macros.svh"

  `RIC_ASSERT_IMP(a_no_overflow, clk, rst, push, count < CNT_W'(DEPTH))
  `RIC_ASSERT_IMP(a_no_underflow, clk, rst, pop, count != '0)

endmodule

`default_nettype wire

>>> rtl/core/ric_back.sv
// ----------------------------------------------------------------------------
// Remote input conditioner back end
// Finishes the arithmetic, updates link and key state, and holds the result
// word in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ric_back import ric_pkg::*; #(
  parameter int MODIFIER_KEY_INDEX = RIC_MODIFIER_KEY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ric_cfg_t    cfg,
  input  wire logic        q_valid,
  input  wire ric_item_t   item,
  output      logic        pop,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      ric_result_t res
);

  localparam logic signed [24:0] SAT_HI = 25'(RIC_Q14_ONE);
  localparam logic signed [24:0] SAT_LO = -SAT_HI;

  logic [31:0]             last_check_ms, last_check_ms_next;
  logic                    check_armed, check_armed_next;
  logic                    link_state, link_state_next;
  logic [RIC_NUM_KEYS-1:0] key_pressed, key_pressed_next;
  logic [RIC_NUM_KEYS-1:0] key_triggered, key_triggered_next;
  logic [RIC_NUM_KEYS-1:0] clicks;
  logic [31:0]             elapsed;
  logic [15:0]             stick_val [4];
  logic signed [24:0]      mouse_half [3];
  logic [15:0]             mouse_val [3];
  logic [6:0][15:0]        norm;
  ric_result_t             res_next;

  // Take the next word when the output register is free or being emptied
  assign pop = q_valid && (!out_valid || out_ready);

  // Stick: apply sign, drop values inside the dead zone
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (item.stick_mag[k] < cfg.dead_zone) begin
        stick_val[k] = '0;
      end else if (item.stick_neg[k]) begin
        stick_val[k] = 16'd0 - {1'b0, item.stick_mag[k]};
      end else begin
        stick_val[k] = {1'b0, item.stick_mag[k]};
      end
    end
  end

  // Mouse: halve toward zero, then saturate
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mouse_half[k] = ($signed(item.mouse_prod[k])
                       + $signed({24'd0, item.mouse_prod[k][24]})) >>> 1;
      if (mouse_half[k] > SAT_HI) begin
        mouse_val[k] = 16'(RIC_Q14_ONE);
      end else if (mouse_half[k] < SAT_LO) begin
        mouse_val[k] = 16'(-RIC_Q14_ONE);
      end else begin
        mouse_val[k] = mouse_half[k][15:0];
      end
    end
  end

  assign elapsed = item.now_ms - last_check_ms;

  // Execute the request against link and key state
  always_comb begin
    last_check_ms_next = last_check_ms;
    check_armed_next   = check_armed;
    link_state_next    = link_state;
    key_pressed_next   = key_pressed;
    key_triggered_next = key_triggered;
    clicks             = '0;
    norm               = '0;
    if (pop) begin
      unique case (item.op)
        OP_FRAME: begin
          check_armed_next   = 1'b0;
          last_check_ms_next = '0;
          link_state_next    = 1'b1;
          key_pressed_next   = item.pressed;
          key_triggered_next = key_triggered & item.pressed;
          norm = {mouse_val[2], mouse_val[1], mouse_val[0],
                  stick_val[3], stick_val[2], stick_val[1], stick_val[0]};
        end
        OP_TICK: begin
          if (!check_armed) begin
            last_check_ms_next = item.now_ms;
            check_armed_next   = 1'b1;
          end else if (elapsed > {16'd0, cfg.link_timeout_ms}) begin
            if (elapsed <= {16'd0, cfg.stale_limit_ms}) begin
              link_state_next = 1'b0;
            end
            check_armed_next   = 1'b0;
            last_check_ms_next = '0;
          end
        end
        OP_SCAN: begin
          // Modifier held suppresses all clicks
          if (!key_pressed[MODIFIER_KEY_INDEX]) begin
            clicks             = cfg.click_enable & key_pressed & ~key_triggered;
            key_triggered_next = key_triggered | clicks;
          end
        end
        OP_NONE: begin
        end
      endcase
    end
  end

  assign res_next = '{norm: norm, link_up: link_state_next,
                      click_events: clicks, pressed_keys: key_pressed_next};

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_check_ms <= '0;
      check_armed   <= 1'b0;
      link_state    <= 1'b0;
      key_pressed   <= '0;
      key_triggered <= '0;
      out_valid     <= 1'b0;
    end else begin
      last_check_ms <= last_check_ms_next;
      check_armed   <= check_armed_next;
      link_state    <= link_state_next;
      key_pressed   <= key_pressed_next;
      key_triggered <= key_triggered_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk) begin
    if (pop) begin
      res <= res_next;
    end
  end

  `include "remote_input_conditioner_macros.svh"

  `RIC_ASSERT_NXT(a_frame_link_up, clk, rst, pop && item.op == OP_FRAME, link_state)
  `RIC_ASSERT_NXT(a_frame_trig_sub, clk, rst, pop && item.op == OP_FRAME, (key_triggered & ~key_pressed) == '0)
  `RIC_ASSERT_IMP(a_disarmed_zero, clk, rst, !check_armed, last_check_ms == '0)
  `RIC_ASSERT_IMP(a_click_pressed, clk, rst, out_valid, (res.click_events & ~res.pressed_keys) == '0)

endmodule

`default_nettype wire

>>> rtl/core/remote_input_conditioner.sv
// An accepted word is registered first in the queue, then in the output register.
// Throughput: one word per cycle while out_ready keeps the output register free.
// The queue registers the front end's products, two entries by default; the back end
// finishes them, updates state and fills a single output register.
// Reset (synchronous, rst high): queue and output empty, link lost, timer
// disarmed, key flags clear, registers at their defaults.
// ----------------------------------------------------------------------------
// Remote input conditioner top level
// Configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_input_conditioner import ric_pkg::*; #(
  parameter int MODIFIER_KEY_INDEX = RIC_MODIFIER_KEY,
  parameter int QUEUE_DEPTH        = RIC_QUEUE_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [17:0]        cfg_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic [10:0]        stick_right_x,
  input  wire logic [10:0]        stick_right_y,
  input  wire logic [10:0]        stick_left_x,
  input  wire logic [10:0]        stick_left_y,
  input  wire logic signed [15:0] mouse_dx,
  input  wire logic signed [15:0] mouse_dy,
  input  wire logic signed [15:0] mouse_dz,
  input  wire logic [7:0]         left_button,
  input  wire logic [7:0]         right_button,
  input  wire logic [15:0]        key_bits,
  input  wire logic [31:0]        now_ms,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic signed [15:0] right_x_norm,
  output      logic signed [15:0] right_y_norm,
  output      logic signed [15:0] left_x_norm,
  output      logic signed [15:0] left_y_norm,
  output      logic signed [15:0] mouse_x_norm,
  output      logic signed [15:0] mouse_y_norm,
  output      logic signed [15:0] mouse_z_norm,
  output      logic               link_up,
  output      logic [17:0]        click_events,
  output      logic [17:0]        pressed_keys
);

  ric_cfg_t    cfg;
  ric_item_t   fe_item;
  ric_item_t   q_item;
  ric_result_t res;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mouse_gain      <= RIC_GAIN_RST;
      cfg.dead_zone       <= RIC_DZ_RST;
      cfg.link_timeout_ms <= RIC_TIMEOUT_RST;
      cfg.stale_limit_ms  <= RIC_STALE_RST;
      cfg.click_enable    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MOUSE_GAIN:   cfg.mouse_gain      <= cfg_data[7:0];
        REG_DEAD_ZONE:    cfg.dead_zone       <= cfg_data[14:0];
        REG_LINK_TIMEOUT: cfg.link_timeout_ms <= cfg_data[15:0];
        REG_STALE_LIMIT:  cfg.stale_limit_ms  <= cfg_data[15:0];
        REG_CLICK_ENABLE: cfg.click_enable    <= cfg_data[RIC_NUM_KEYS-1:0];
        default: begin
        end
      endcase
    end
  end

  ric_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .stick_right_x (stick_right_x),
    .stick_right_y (stick_right_y),
    .stick_left_x  (stick_left_x),
    .stick_left_y  (stick_left_y),
    .mouse_dx      (mouse_dx),
    .mouse_dy      (mouse_dy),
    .mouse_dz      (mouse_dz),
    .left_button   (left_button),
    .right_button  (right_button),
    .key_bits      (key_bits),
    .now_ms        (now_ms),
    .mouse_gain    (cfg.mouse_gain),
    .q_full        (q_full),
    .push          (push),
    .item          (fe_item)
  );

  ric_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (fe_item),
    .full    (q_full),
    .pop     (pop),
    .q_valid (q_valid),
    .rd_item (q_item)
  );

  ric_back #(
    .MODIFIER_KEY_INDEX (MODIFIER_KEY_INDEX)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .item      (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Unpack the result word onto the ports
  assign right_x_norm = $signed(res.norm[0]);
  assign right_y_norm = $signed(res.norm[1]);
  assign left_x_norm  = $signed(res.norm[2]);
  assign left_y_norm  = $signed(res.norm[3]);
  assign mouse_x_norm = $signed(res.norm[4]);
  assign mouse_y_norm = $signed(res.norm[5]);
  assign mouse_z_norm = $signed(res.norm[6]);
  assign link_up      = res.link_up;
  assign click_events = res.click_events;
  assign pressed_keys = res.pressed_keys;

endmodule

`default_nettype wire

>>> test/remote_input_conditioner_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Remote input conditioner regression
// Drives frame, tick, scan and unused words through the valid/ready input,
// predicts every result word from a local copy of the conditioner state and
// checks each output word field by field. Register settings change between
// phases, with random idling on both sides of the block.
// ----------------------------------------------------------------------------

module remote_input_conditioner_test;
  import ric_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STICK_SPAN   = 660;
  localparam int MAX_IDLE     = 10;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_WORDS  = 206;
  localparam int SETTLE_TICKS = 8;
  // First stick offset that lands on or outside the reset dead zone
  localparam int DZ_EDGE      = 33;
  // Indexes past the last register, ignored by the block
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    ric_op_t          op;
    logic [3:0][10:0] stick;   // right_x, right_y, left_x, left_y from bit 0 up
    logic [2:0][15:0] mouse;   // dx, dy, dz from bit 0 up
    logic [7:0]       lbtn;
    logic [7:0]       rbtn;
    logic [15:0]      keys;
    logic [31:0]      now;
  } ctl_word_t;

  typedef struct packed {
    logic [6:0][15:0]        norm;
    logic                    link;
    logic [RIC_NUM_KEYS-1:0] clicks;
    logic [RIC_NUM_KEYS-1:0] pressed;
  } cond_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [17:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [1:0] req_type;
  logic [10:0] stick_right_x, stick_right_y, stick_left_x, stick_left_y;
  logic signed [15:0] mouse_dx, mouse_dy, mouse_dz;
  logic [7:0] left_button, right_button;
  logic [15:0] key_bits;
  logic [31:0] now_ms;
  logic out_valid;
  logic out_ready;
  logic signed [15:0] right_x_norm, right_y_norm, left_x_norm, left_y_norm;
  logic signed [15:0] mouse_x_norm, mouse_y_norm, mouse_z_norm;
  logic link_up;
  logic [17:0] click_events;
  logic [17:0] pressed_keys;

  // Local copy of the registers
  logic [7:0]              p_gain;
  logic [14:0]             p_dz;
  logic [15:0]             p_timeout;
  logic [15:0]             p_stale;
  logic [RIC_NUM_KEYS-1:0] p_enable;

  // Local copy of the conditioner state
  logic [31:0]             s_last;
  logic                    s_armed;
  logic                    s_link;
  logic [RIC_NUM_KEYS-1:0] s_pressed;
  logic [RIC_NUM_KEYS-1:0] s_trig;

  cond_result_t cond_expect_q[$];
  int    mismatch_count = 0;
  int    cycle_count = 0;
  bit    tx_calm = 1'b0;
  bit    rx_calm = 1'b0;
  string norm_names[7] = '{"right_x_norm", "right_y_norm", "left_x_norm", "left_y_norm",
                           "mouse_x_norm", "mouse_y_norm", "mouse_z_norm"};

  remote_input_conditioner dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .stick_right_x (stick_right_x),
    .stick_right_y (stick_right_y),
    .stick_left_x  (stick_left_x),
    .stick_left_y  (stick_left_y),
    .mouse_dx      (mouse_dx),
    .mouse_dy      (mouse_dy),
    .mouse_dz      (mouse_dz),
    .left_button   (left_button),
    .right_button  (right_button),
    .key_bits      (key_bits),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .right_x_norm  (right_x_norm),
    .right_y_norm  (right_y_norm),
    .left_x_norm   (left_x_norm),
    .left_y_norm   (left_y_norm),
    .mouse_x_norm  (mouse_x_norm),
    .mouse_y_norm  (mouse_y_norm),
    .mouse_z_norm  (mouse_z_norm),
    .link_up       (link_up),
    .click_events  (click_events),
    .pressed_keys  (pressed_keys)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // Map a raw stick to Q2.14, truncated, then apply the dead zone
  function automatic logic [15:0] stick_q14(input logic [10:0] raw);
    int c;
    int v;
    int dz;
    c  = int'(raw) - RIC_STICK_CENTER;
    v  = (c * RIC_Q14_ONE) / STICK_SPAN;
    dz = int'(p_dz);
    if (v < dz && v > -dz) v = 0;
    return 16'(v);
  endfunction

  // Scale a mouse axis by gain/2, truncated, then saturate
  function automatic logic [15:0] mouse_q14(input logic signed [15:0] raw);
    int v;
    v = (int'(p_gain) * int'(raw)) / 2;
    if (v > RIC_Q14_ONE) v = RIC_Q14_ONE;
    if (v < -RIC_Q14_ONE) v = -RIC_Q14_ONE;
    return 16'(v);
  endfunction

  // Advance the local state by one word and return the result it yields
  function automatic cond_result_t condition_word(input ctl_word_t w);
    cond_result_t r;
    logic [31:0] dt;
    r = '0;
    case (w.op)
      OP_FRAME: begin
        s_armed = 1'b0;
        s_last  = '0;
        s_link  = 1'b1;
        for (int k = 0; k < 4; k++) r.norm[k] = stick_q14(w.stick[k]);
        for (int k = 0; k < 3; k++) r.norm[4 + k] = mouse_q14(w.mouse[k]);
        s_pressed = {w.rbtn == 8'd1, w.lbtn == 8'd1, w.keys};
        s_trig &= s_pressed;
      end
      OP_TICK: begin
        if (!s_armed) begin
          s_last  = w.now;
          s_armed = 1'b1;
        end else begin
          dt = w.now - s_last;
          if (dt > 32'(p_timeout)) begin
            if (dt <= 32'(p_stale)) s_link = 1'b0;
            s_armed = 1'b0;
            s_last  = '0;
          end
        end
      end
      OP_SCAN: begin
        if (!s_pressed[RIC_MODIFIER_KEY]) begin
          r.clicks = p_enable & s_pressed & ~s_trig;
          s_trig |= r.clicks;
        end
      end
      default: ;
    endcase
    r.link    = s_link;
    r.pressed = s_pressed;
    return r;
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // Check each finished word, then predict each accepted one
  always @(posedge clk) begin
    cond_result_t seen;
    cond_result_t want;
    ctl_word_t    taken;
    if (!rst) begin
      if (out_valid && out_ready) begin
        seen.norm    = {mouse_z_norm, mouse_y_norm, mouse_x_norm,
                        left_y_norm, left_x_norm, right_y_norm, right_x_norm};
        seen.link    = link_up;
        seen.clicks  = click_events;
        seen.pressed = pressed_keys;
        if (cond_expect_q.size() == 0) begin
          flag_mismatch("result word with no word pending");
        end else begin
          want = cond_expect_q.pop_front();
          for (int k = 0; k < 7; k++) begin
            if (seen.norm[k] !== want.norm[k])
              flag_mismatch($sformatf("%s got %0d want %0d", norm_names[k],
                                      $signed(seen.norm[k]), $signed(want.norm[k])));
          end
          if (seen.link !== want.link)
            flag_mismatch($sformatf("link_up got %b want %b", seen.link, want.link));
          if (seen.clicks !== want.clicks)
            flag_mismatch($sformatf("click_events got %h want %h", seen.clicks, want.clicks));
          if (seen.pressed !== want.pressed)
            flag_mismatch($sformatf("pressed_keys got %h want %h",
                                    seen.pressed, want.pressed));
        end
      end
      if (in_valid && in_ready) begin
        taken.op    = ric_op_t'(req_type);
        taken.stick = {stick_left_y, stick_left_x, stick_right_y, stick_right_x};
        taken.mouse = {mouse_dz, mouse_dy, mouse_dx};
        taken.lbtn  = left_button;
        taken.rbtn  = right_button;
        taken.keys  = key_bits;
        taken.now   = now_ms;
        cond_expect_q.push_back(condition_word(taken));
      end
    end
  end

  // Accept result words, stalling a random number of cycles before each
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      @(negedge clk);
    end
  end

  // ----------------------------------------------------------------- stimulus

  // Random content for every field; callers override what they need
  function automatic ctl_word_t make_word(input ric_op_t op);
    ctl_word_t w;
    w.op = op;
    for (int k = 0; k < 4; k++)
      w.stick[k] = ($urandom_range(0, 3) == 0) ?
                   11'(RIC_STICK_CENTER - 40 + $urandom_range(0, 80)) : 11'($urandom);
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 2))
        0:       w.mouse[k] = 16'($urandom);
        1:       w.mouse[k] = 16'($urandom_range(0, 400) - 200);
        default: w.mouse[k] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      endcase
    end
    w.lbtn = $urandom_range(0, 1) ? 8'd1 : 8'($urandom);
    w.rbtn = $urandom_range(0, 1) ? 8'd1 : 8'($urandom);
    w.keys = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom & $urandom & $urandom);
    if ($urandom_range(0, 9) < 7) w.keys[RIC_MODIFIER_KEY] = 1'b0;
    w.now = $urandom;
    return w;
  endfunction

  // Present one word after a random gap and hold it until accepted
  task automatic send_word(input ctl_word_t w);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type      <= w.op;
    stick_right_x <= w.stick[0];
    stick_right_y <= w.stick[1];
    stick_left_x  <= w.stick[2];
    stick_left_y  <= w.stick[3];
    mouse_dx      <= w.mouse[0];
    mouse_dy      <= w.mouse[1];
    mouse_dz      <= w.mouse[2];
    left_button   <= w.lbtn;
    right_button  <= w.rbtn;
    key_bits      <= w.keys;
    now_ms        <= w.now;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drop valid and hold until every pending result word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (cond_expect_q.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Write one register; leaves the write enable high for the next one
  task automatic write_reg(input logic [2:0] idx, input logic [17:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_MOUSE_GAIN:   p_gain    = value[7:0];
      REG_DEAD_ZONE:    p_dz      = value[14:0];
      REG_LINK_TIMEOUT: p_timeout = value[15:0];
      REG_STALE_LIMIT:  p_stale   = value[15:0];
      REG_CLICK_ENABLE: p_enable  = value[RIC_NUM_KEYS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Program all registers, junk in the unused upper bits, plus a spare index
  task automatic apply_settings(input logic [7:0] gain, input logic [14:0] dz,
                                input logic [15:0] tmo, input logic [15:0] stale,
                                input logic [RIC_NUM_KEYS-1:0] en);
    write_reg(REG_MOUSE_GAIN, {10'($urandom), gain});
    write_reg(REG_DEAD_ZONE, {3'($urandom), dz});
    write_reg(REG_LINK_TIMEOUT, {2'($urandom), tmo});
    write_reg(REG_STALE_LIMIT, {2'($urandom), stale});
    write_reg(REG_CLICK_ENABLE, en);
    write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 18'($urandom));
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------- test tasks

  // Field extremes, dead-zone edges, unused code and wrapping ticks at reset
  task automatic test_field_extremes();
    ctl_word_t w;
    send_word(make_word(OP_NONE));
    send_word(make_word(OP_SCAN));
    // Arm near the top of the time range, then cross the wrap
    w = make_word(OP_TICK);
    w.now = 32'hFFFF_FFF0;
    send_word(w);
    w.now = 32'h0000_0050;
    send_word(w);
    w.now = 32'h0000_0055;
    send_word(w);
    // Sticks listed as left_y, left_x, right_y, right_x
    w = make_word(OP_FRAME);
    w.stick = {11'(RIC_STICK_CENTER + DZ_EDGE), 11'(RIC_STICK_CENTER), 11'h7FF, 11'h000};
    w.mouse = {16'h0000, 16'h7FFF, 16'h8000};
    w.lbtn  = 8'd1;
    w.rbtn  = 8'hFF;
    w.keys  = 16'hFFFF;
    send_word(w);
    w.stick = {11'd1, 11'(RIC_STICK_CENTER - DZ_EDGE + 1), 11'(RIC_STICK_CENTER + DZ_EDGE - 1),
               11'(RIC_STICK_CENTER - DZ_EDGE)};
    w.mouse = {16'hFEFF, 16'h0101, 16'hFFFF};
    w.lbtn  = 8'd2;
    w.rbtn  = 8'd1;
    w.keys  = 16'h0000;
    send_word(w);
  endtask

  // Timeout, stale restart and re-arming with the reset limits
  task automatic test_link_timer();
    ctl_word_t w;
    w = make_word(OP_TICK);
    w.now = 32'd1000;
    send_word(w);
    w.now = 32'd1100;
    send_word(w);
    w.now = 32'd1101;
    send_word(w);
    send_word(make_word(OP_FRAME));
    w.now = 32'd5000;
    send_word(w);
    w.now = 32'd6001;
    send_word(w);
    w.now = 32'd7000;
    send_word(w);
    w.now = 32'd8000;
    send_word(w);
  endtask

  // Click once per press, re-fire after release, block while modifier is held
  task automatic test_click_scan();
    ctl_word_t w;
    ctl_word_t scan;
    wait_drained();
    apply_settings(p_gain, p_dz, p_timeout, p_stale, {RIC_NUM_KEYS{1'b1}});
    scan = make_word(OP_SCAN);
    w = make_word(OP_FRAME);
    w.lbtn = 8'd1;
    w.rbtn = 8'd0;
    w.keys = 16'h0003;
    send_word(w);
    send_word(scan);
    send_word(scan);
    w.keys = 16'h0002;
    send_word(w);
    w.keys = 16'h0083;
    send_word(w);
    w.keys[RIC_MODIFIER_KEY] = 1'b1;
    send_word(w);
    send_word(scan);
    w.keys[RIC_MODIFIER_KEY] = 1'b0;
    send_word(w);
    send_word(scan);
  endtask

  // Random words over several register settings, extremes first
  task automatic test_random_traffic();
    ctl_word_t w;
    logic [31:0] base;
    logic [31:0] delta;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      case (phase)
        0: apply_settings('0, '0, '0, '0, '0);
        1: apply_settings(8'hFF, 15'(RIC_Q14_ONE), 16'hFFFF, 16'hFFFF, {RIC_NUM_KEYS{1'b1}});
        default: apply_settings(
            $urandom_range(0, 2) == 0 ? 8'($urandom_range(0, 1) * 255) : 8'($urandom),
            $urandom_range(0, 1) ? 15'($urandom_range(0, 2000))
                                 : 15'($urandom_range(0, RIC_Q14_ONE)),
            $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 2000)),
            $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3000)),
            $urandom_range(0, 3) == 0 ? {RIC_NUM_KEYS{1'b1}} : RIC_NUM_KEYS'($urandom));
      endcase
      for (int i = 0; i < PHASE_WORDS; i++) begin
        // Switch between idling and back-to-back stretches
        if (i % 50 == 0) begin
          tx_calm = ($urandom_range(0, 3) == 0);
          rx_calm = ($urandom_range(0, 3) == 0);
        end
        if ($urandom_range(0, 199) == 0) wait_drained();
        case ($urandom_range(0, 19))
          0,1,2,3,4,5,6,7: w = make_word(OP_FRAME);
          8,9,10,11,12,13: begin
            // Aim the tick near the limits, measured from the armed start
            w = make_word(OP_TICK);
            base = s_armed ? s_last : $urandom;
            case ($urandom_range(0, 5))
              0:       delta = 32'(p_timeout) + $urandom_range(0, 2) - 1;
              1:       delta = 32'(p_stale) + $urandom_range(0, 2) - 1;
              2:       delta = $urandom_range(0, 2 * int'(p_stale) + 2);
              3:       delta = $urandom;
              default: delta = $urandom_range(0, p_timeout);
            endcase
            w.now = base + delta;
          end
          19:      w = make_word(OP_NONE);
          default: w = make_word(OP_SCAN);
        endcase
        send_word(w);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_valid      = 1'b0;
    req_type      = OP_NONE;
    stick_right_x = '0;
    stick_right_y = '0;
    stick_left_x  = '0;
    stick_left_y  = '0;
    mouse_dx      = '0;
    mouse_dy      = '0;
    mouse_dz      = '0;
    left_button   = '0;
    right_button  = '0;
    key_bits      = '0;
    now_ms        = '0;
    p_gain        = RIC_GAIN_RST;
    p_dz          = RIC_DZ_RST;
    p_timeout     = RIC_TIMEOUT_RST;
    p_stale       = RIC_STALE_RST;
    p_enable      = '0;
    s_last        = '0;
    s_armed       = 1'b0;
    s_link        = 1'b0;
    s_pressed     = '0;
    s_trig        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_field_extremes();
    test_link_timer();
    test_click_scan();
    test_random_traffic();

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatch_count == 0 && cond_expect_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> remote_input_conditioner.f
+incdir+rtl/core
rtl/core/ric_pkg.sv
rtl/core/ric_front.sv
rtl/core/ric_queue.sv
rtl/core/ric_back.sv
rtl/core/remote_input_conditioner.sv
test/remote_input_conditioner_test.sv
